### design/lgm_pkg.sv
package lgm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam logic [Q_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  localparam int CH_W      = 8;
  localparam int COLOR_W   = 3 * CH_W;
  localparam int CFG_W     = COLOR_W;
  localparam int CFG_IDX_W = 3;

  localparam int LUMA_SHIFT = 16;
  localparam int PROD_W     = 24;
  localparam logic [15:0] LUMA_R_COEF = 16'd19595;
  localparam logic [15:0] LUMA_G_COEF = 16'd38470;
  localparam logic [15:0] LUMA_B_COEF = 16'd7471;
  localparam logic [CH_W-1:0] LUMA_MAX = 8'hFF;

  localparam int BLEND_W = Q_W + CH_W;

  localparam logic [COLOR_W-1:0] COLOR_A_RST = 24'h000080;
  localparam logic [COLOR_W-1:0] COLOR_B_RST = 24'hFF00FF;
  localparam logic [COLOR_W-1:0] COLOR_C_RST = 24'h00FFFF;
  localparam logic [COLOR_W-1:0] COLOR_D_RST = 24'hFFFFFF;
  localparam logic [Q_W-1:0]     SPLIT_LOW_RST  = 17'd21627;
  localparam logic [Q_W-1:0]     SPLIT_HIGH_RST = 17'd43254;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_A    = 3'd0,
    CFG_COLOR_B    = 3'd1,
    CFG_COLOR_C    = 3'd2,
    CFG_COLOR_D    = 3'd3,
    CFG_SPLIT_LOW  = 3'd4,
    CFG_SPLIT_HIGH = 3'd5,
    CFG_ENABLE     = 3'd6,
    CFG_GRAY       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t lo;
    rgb_t hi;
  } ends_t;

  typedef struct packed {
    logic [Q_W-1:0] num;
    logic [Q_W-1:0] den;
    ends_t          ends;
  } div_in_t;

  typedef struct packed {
    logic [Q_W-1:0] amount;
    ends_t          ends;
  } div_out_t;

  typedef struct packed {
    rgb_t           color_a;
    rgb_t           color_b;
    rgb_t           color_c;
    rgb_t           color_d;
    logic [Q_W-1:0] split_low;
    logic [Q_W-1:0] split_high;
    logic           effect_enable;
    logic           gray_input;
  } cfg_t;

endpackage

### design/lgm_front.sv
module lgm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  lgm_pkg::rgb_t       in_pix,
  input  lgm_pkg::cfg_t       cfg,
  output logic                out_valid,
  output lgm_pkg::div_in_t    out_data
);

  lgm_pkg::rgb_t                   pix_g;
  logic [lgm_pkg::PROD_W-1:0]      pr_nxt, pg_nxt, pb_nxt;
  logic                            v1_r;
  lgm_pkg::rgb_t                   pix1_r;
  logic [lgm_pkg::PROD_W-1:0]      pr_r, pg_r, pb_r;

  logic [lgm_pkg::PROD_W-1:0]      sum;
  logic [lgm_pkg::CH_W-1:0]        luma;
  logic [lgm_pkg::Q_W-1:0]         pct_nxt;
  logic                            v2_r;
  lgm_pkg::rgb_t                   pix2_r;
  logic [lgm_pkg::Q_W-1:0]         pct_r;

  logic                            lt_low, lt_high, top_open;
  lgm_pkg::div_in_t                seg_nxt;
  logic                            v3_r;
  lgm_pkg::div_in_t                seg_r;

  always_comb begin
    pix_g = in_pix;
    if (cfg.gray_input) begin
      pix_g.green = in_pix.red;
      pix_g.blue  = in_pix.red;
    end
    pr_nxt = lgm_pkg::PROD_W'(lgm_pkg::LUMA_R_COEF) * lgm_pkg::PROD_W'(pix_g.red);
    pg_nxt = lgm_pkg::PROD_W'(lgm_pkg::LUMA_G_COEF) * lgm_pkg::PROD_W'(pix_g.green);
    pb_nxt = lgm_pkg::PROD_W'(lgm_pkg::LUMA_B_COEF) * lgm_pkg::PROD_W'(pix_g.blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      pix1_r <= pix_g;
      pr_r   <= pr_nxt;
      pg_r   <= pg_nxt;
      pb_r   <= pb_nxt;
    end
  end

  // Since 2^16 = 255 * 257 + 1, luma * 2^16 / 255 is luma * 257 plus one at full scale.
  always_comb begin
    sum     = pr_r + pg_r + pb_r;
    luma    = sum[lgm_pkg::LUMA_SHIFT +: lgm_pkg::CH_W];
    pct_nxt = {1'b0, luma, luma} + lgm_pkg::Q_W'(luma == lgm_pkg::LUMA_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      pix2_r <= pix1_r;
      pct_r  <= pct_nxt;
    end
  end

  // A pass-through or a fixed colour is sent as a blend with zero amount.
  always_comb begin
    lt_low   = pct_r < cfg.split_low;
    lt_high  = pct_r < cfg.split_high;
    top_open = cfg.split_high < lgm_pkg::ONE_Q;
    seg_nxt.num     = '0;
    seg_nxt.den     = lgm_pkg::Q_W'(1);
    seg_nxt.ends.lo = pix2_r;
    seg_nxt.ends.hi = pix2_r;
    if (cfg.effect_enable) begin
      if (lt_low) begin
        seg_nxt.num     = pct_r;
        seg_nxt.den     = cfg.split_low;
        seg_nxt.ends.lo = cfg.color_a;
        seg_nxt.ends.hi = cfg.color_b;
      end else if (lt_high) begin
        seg_nxt.num     = pct_r - cfg.split_low;
        seg_nxt.den     = cfg.split_high - cfg.split_low;
        seg_nxt.ends.lo = cfg.color_b;
        seg_nxt.ends.hi = cfg.color_c;
      end else if (top_open) begin
        seg_nxt.num     = pct_r - cfg.split_high;
        seg_nxt.den     = lgm_pkg::ONE_Q - cfg.split_high;
        seg_nxt.ends.lo = cfg.color_c;
        seg_nxt.ends.hi = cfg.color_d;
      end else begin
        seg_nxt.ends.lo = cfg.color_d;
        seg_nxt.ends.hi = cfg.color_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      seg_r <= seg_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = seg_r;

endmodule

### design/lgm_div.sv
module lgm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  lgm_pkg::div_in_t    in_data,
  output logic                out_valid,
  output lgm_pkg::div_out_t   out_data
);

  logic                     v_r    [lgm_pkg::Q_W];
  logic [lgm_pkg::Q_W-1:0]  rem_r  [lgm_pkg::Q_W];
  logic [lgm_pkg::Q_W-1:0]  den_r  [lgm_pkg::Q_W];
  logic [lgm_pkg::Q_W-1:0]  quo_r  [lgm_pkg::Q_W];
  lgm_pkg::ends_t           ends_r [lgm_pkg::Q_W];

  // Restoring division, one quotient bit per stage, most significant first.
  // The numerator never exceeds the divisor, so the quotient fits in Q_W bits.
  for (genvar k = 0; k < lgm_pkg::Q_W; k++) begin : g_stage
    logic [lgm_pkg::Q_W:0]   x;
    logic [lgm_pkg::Q_W-1:0] d_in, q_in, rem_nxt, quo_nxt;
    logic                    v_in, ge;
    lgm_pkg::ends_t          e_in;

    if (k == 0) begin : g_first
      assign x    = {1'b0, in_data.num};
      assign d_in = in_data.den;
      assign q_in = '0;
      assign v_in = in_valid;
      assign e_in = in_data.ends;
    end else begin : g_next
      assign x    = {rem_r[k-1], 1'b0};
      assign d_in = den_r[k-1];
      assign q_in = quo_r[k-1];
      assign v_in = v_r[k-1];
      assign e_in = ends_r[k-1];
    end

    always_comb begin
      ge      = x >= {1'b0, d_in};
      rem_nxt = ge ? lgm_pkg::Q_W'(x - {1'b0, d_in}) : lgm_pkg::Q_W'(x);
      quo_nxt = q_in;
      quo_nxt[lgm_pkg::Q_W-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= d_in;
        quo_r[k]  <= quo_nxt;
        ends_r[k] <= e_in;
      end
    end
  end

  assign out_valid       = v_r[lgm_pkg::Q_W-1];
  assign out_data.amount = quo_r[lgm_pkg::Q_W-1];
  assign out_data.ends   = ends_r[lgm_pkg::Q_W-1];

endmodule

### design/lgm_blend.sv
module lgm_blend (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                gray,
  input  logic                in_valid,
  input  lgm_pkg::div_out_t   in_data,
  output logic                out_valid,
  output lgm_pkg::rgb_t       out_pix
);

  logic [lgm_pkg::CH_W-1:0]    lo_ch [3];
  logic [lgm_pkg::CH_W-1:0]    hi_ch [3];
  logic [lgm_pkg::Q_W-1:0]     w_lo;
  logic [lgm_pkg::BLEND_W-1:0] plo_nxt [3];
  logic [lgm_pkg::BLEND_W-1:0] phi_nxt [3];
  logic                        v1_r;
  logic [lgm_pkg::BLEND_W-1:0] plo_r [3];
  logic [lgm_pkg::BLEND_W-1:0] phi_r [3];

  logic [lgm_pkg::BLEND_W:0]   sum [3];
  logic [lgm_pkg::CH_W-1:0]    ch  [3];
  lgm_pkg::rgb_t               pix_nxt;
  logic                        v2_r;
  lgm_pkg::rgb_t               pix_r;

  assign lo_ch[0] = in_data.ends.lo.red;
  assign lo_ch[1] = in_data.ends.lo.green;
  assign lo_ch[2] = in_data.ends.lo.blue;
  assign hi_ch[0] = in_data.ends.hi.red;
  assign hi_ch[1] = in_data.ends.hi.green;
  assign hi_ch[2] = in_data.ends.hi.blue;
  assign w_lo     = lgm_pkg::ONE_Q - in_data.amount;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      plo_nxt[c] = lgm_pkg::BLEND_W'(lo_ch[c]) * lgm_pkg::BLEND_W'(w_lo);
      phi_nxt[c] = lgm_pkg::BLEND_W'(hi_ch[c]) * lgm_pkg::BLEND_W'(in_data.amount);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = {1'b0, plo_r[c]} + {1'b0, phi_r[c]};
      ch[c]  = sum[c][lgm_pkg::FRAC_BITS +: lgm_pkg::CH_W];
    end
    pix_nxt.red   = ch[0];
    pix_nxt.green = gray ? ch[0] : ch[1];
    pix_nxt.blue  = gray ? ch[0] : ch[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_pix   = pix_r;

endmodule

### design/luma_gradient_map.sv
// Items flow through lgm_front, lgm_div, lgm_blend and then the output register.
// Throughput: one item per cycle, barring stalls; the 17-stage restoring divider sets depth.
// A one-entry skid register behind the output register raises in_stall only once it is full.
// Reset (rst_n low, synchronous) empties the pipeline and loads every configuration
// register with its default colour, threshold and mode value.
module luma_gradient_map (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  input  logic                            cfg_we,
  input  logic [lgm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lgm_pkg::CFG_W-1:0]       cfg_wdata
);

  lgm_pkg::cfg_t      cfg_r;
  lgm_pkg::rgb_t      in_pix;
  logic               en;

  logic               seg_valid;
  lgm_pkg::div_in_t   seg_data;
  logic               div_valid;
  lgm_pkg::div_out_t  div_data;
  logic               push_valid;
  lgm_pkg::rgb_t      push_pix;

  logic               out_valid_r, out_valid_nxt;
  lgm_pkg::rgb_t      out_pix_r, out_pix_nxt;
  logic               skid_full_r, skid_full_nxt;
  lgm_pkg::rgb_t      skid_pix_r, skid_pix_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_a       <= lgm_pkg::COLOR_A_RST;
      cfg_r.color_b       <= lgm_pkg::COLOR_B_RST;
      cfg_r.color_c       <= lgm_pkg::COLOR_C_RST;
      cfg_r.color_d       <= lgm_pkg::COLOR_D_RST;
      cfg_r.split_low     <= lgm_pkg::SPLIT_LOW_RST;
      cfg_r.split_high    <= lgm_pkg::SPLIT_HIGH_RST;
      cfg_r.effect_enable <= 1'b0;
      cfg_r.gray_input    <= 1'b0;
    end else if (cfg_we) begin
      case (lgm_pkg::cfg_idx_t'(cfg_index))
        lgm_pkg::CFG_COLOR_A:    cfg_r.color_a       <= lgm_pkg::rgb_t'(cfg_wdata);
        lgm_pkg::CFG_COLOR_B:    cfg_r.color_b       <= lgm_pkg::rgb_t'(cfg_wdata);
        lgm_pkg::CFG_COLOR_C:    cfg_r.color_c       <= lgm_pkg::rgb_t'(cfg_wdata);
        lgm_pkg::CFG_COLOR_D:    cfg_r.color_d       <= lgm_pkg::rgb_t'(cfg_wdata);
        lgm_pkg::CFG_SPLIT_LOW:  cfg_r.split_low     <= cfg_wdata[lgm_pkg::Q_W-1:0];
        lgm_pkg::CFG_SPLIT_HIGH: cfg_r.split_high    <= cfg_wdata[lgm_pkg::Q_W-1:0];
        lgm_pkg::CFG_ENABLE:     cfg_r.effect_enable <= cfg_wdata[0];
        lgm_pkg::CFG_GRAY:       cfg_r.gray_input    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_pix.red   = in_red;
  assign in_pix.green = in_green;
  assign in_pix.blue  = in_blue;
  assign en           = ~skid_full_r;
  assign in_stall     = skid_full_r;

  lgm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_pix    (in_pix),
    .cfg       (cfg_r),
    .out_valid (seg_valid),
    .out_data  (seg_data)
  );

  lgm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (seg_valid),
    .in_data   (seg_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  lgm_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .gray      (cfg_r.gray_input),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .out_valid (push_valid),
    .out_pix   (push_pix)
  );

  // The pipeline advances only while the skid register is empty, so an item
  // leaving the last stage always has a place to go.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    skid_full_nxt = skid_full_r;
    skid_pix_nxt  = skid_pix_r;
    if (skid_full_r) begin
      if (!out_stall) begin
        out_pix_nxt   = skid_pix_r;
        skid_full_nxt = 1'b0;
      end
    end else if (out_valid_r && out_stall) begin
      if (push_valid) begin
        skid_full_nxt = 1'b1;
        skid_pix_nxt  = push_pix;
      end
    end else begin
      out_valid_nxt = push_valid;
      out_pix_nxt   = push_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
    out_pix_r  <= out_pix_nxt;
    skid_pix_r <= skid_pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_pix_r.red;
  assign out_green = out_pix_r.green;
  assign out_blue  = out_pix_r.blue;

endmodule

### design/lgm_checker.sv
module lgm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled result changed or vanished");

  // Input back-pressure only appears when a result is waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && $past(out_valid && out_stall))
    else $error("in_stall raised without a stalled result");

  // The input side reopens only after the output has taken an item.
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) && $past(rst_n) |-> $past(!out_stall))
    else $error("in_stall dropped while the output was stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not empty the block");

endmodule

bind luma_gradient_map lgm_checker u_lgm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);
